@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the date arithmetic RTL.
// Define ASSERT_OFF to compile all checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// post must hold in the cycle after pre
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

@@ rtl/core/gda_pkg.sv @@
// Types, constants and small tables for the Gregorian date arithmetic core.
// No dependencies.
`default_nettype none

package gda_pkg;

  // pipeline depth, input register to output register
  localparam int NSTG = 11;

  // reciprocals for exact division by constants over the operand ranges used
  localparam logic [15:0] K100 = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
  localparam logic [25:0] KB   = 26'(((64'd1 << 43) + 64'd146096) / 64'd146097);
  localparam logic [18:0] KD   = 19'(((64'd1 << 29) + 64'd1460) / 64'd1461);
  localparam logic [11:0] KM   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  // day numbers of -4700-01-01 and 9999-12-31
  localparam logic signed [25:0] JD_LO = 26'sd4421;
  localparam logic signed [25:0] JD_HI = 26'sd5373484;

  localparam logic signed [25:0] DIFF_MAX = 26'sd8388607;
  localparam logic signed [25:0] DIFF_MIN = -26'sd8388608;

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef struct packed {
    logic [14:0]        ay;    // |y| where y = year + 4800 - a
    logic               neg;   // y < 0
    logic signed [16:0] base;  // day + (153m+2)/5 - 32045
  } prep_t;

  typedef struct packed {
    logic signed [23:0] diff;
    logic               oor;
    logic               valid;
    logic               equal;
  } tail_t;

  // (153*m + 2) / 5
  function automatic logic [8:0] mday_ofs(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd398;
      4'd14:   r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m) inside
      MON_FEB:                           r = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: r = 5'd30;
      default:                           r = 5'd31;
    endcase
    return r;
  endfunction

  // shifted-March month index, magnitude of y and constant part of the day number
  function automatic prep_t jdn_prep(input logic signed [14:0] yr, input logic [3:0] mo,
                                     input logic [4:0] dy);
    logic               a;
    logic [3:0]         m;
    logic signed [15:0] y;
    logic signed [15:0] ya;
    prep_t              p;
    a      = (mo <= MON_FEB);
    m      = a ? mo + 4'd9 : mo - 4'd3;
    y      = 16'(yr) + 16'sd4800 - $signed({15'd0, a});
    ya     = y[15] ? -y : y;
    p.ay   = ya[14:0];
    p.neg  = y[15];
    p.base = $signed({12'd0, dy}) + $signed({8'd0, mday_ofs(m)}) - 17'sd32045;
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/gregorian_date_arithmetic_core.sv @@
// Gregorian date arithmetic: day number, offset shift, difference and checks.
// Takes one item per cycle unless the output stalls with every stage full.
// Depth is set by the chain of reciprocal divides in the day-number-to-date path.
// Stages with no item collapse, so the input keeps taking items while a result waits, until every stage is full.
// Synchronous reset clears the stage valid bits only; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module gregorian_date_arithmetic_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [14:0] year,
  input  logic        [3:0]  month,
  input  logic        [4:0]  day,
  input  logic signed [22:0] offset_days,
  input  logic signed [14:0] other_year,
  input  logic        [3:0]  other_month,
  input  logic        [4:0]  other_day,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] shifted_year,
  output logic        [3:0]  shifted_month,
  output logic        [4:0]  shifted_day,
  output logic               shift_out_of_range,
  output logic signed [23:0] day_difference,
  output logic               date_valid,
  output logic               dates_equal
);
  import gda_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_next;
  logic [NSTG-1:0] adv;

  // a stage moves when the output drains or it or any later stage is empty
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      adv[k] = !out_stall || (|(~vld >> k));
    end
    vld_next[0] = adv[0] ? in_valid : vld[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_next[k] = adv[k] ? vld[k-1] : vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld[NSTG-1];

  // stage 0: month remap, |y|, |year|, constant day-number part, date equality
  prep_t              p1, p2;
  logic signed [15:0] ys;
  logic [14:0]        n1;

  always_comb begin
    p1 = jdn_prep(year, month, day);
    p2 = jdn_prep(other_year, other_month, other_day);
    ys = 16'(year);
    n1 = ys[15] ? 15'(-ys) : ys[14:0];
  end

  prep_t              s0_p1, s0_p2;
  logic [14:0]        s0_n1;
  logic [3:0]         s0_m1;
  logic [4:0]         s0_d1;
  logic               s0_equal;
  logic signed [22:0] s0_off;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_p1    <= p1;
      s0_p2    <= p2;
      s0_n1    <= n1;
      s0_m1    <= month;
      s0_d1    <= day;
      s0_equal <= (year == other_year) && (month == other_month) && (day == other_day);
      s0_off   <= offset_days;
    end
  end

  // stage 1: /100 by reciprocal, 365*|y|
  logic [30:0] pq1, pq2, pqn;

  always_comb begin
    pq1 = 31'(s0_p1.ay) * 31'(K100);
    pq2 = 31'(s0_p2.ay) * 31'(K100);
    pqn = 31'(s0_n1) * 31'(K100);
  end

  prep_t              s1_p1, s1_p2;
  logic [8:0]         s1_q1, s1_q2, s1_qn;
  logic [23:0]        s1_y365_1, s1_y365_2;
  logic [14:0]        s1_n1;
  logic [3:0]         s1_m1;
  logic [4:0]         s1_d1;
  logic               s1_equal;
  logic signed [22:0] s1_off;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_p1     <= s0_p1;
      s1_p2     <= s0_p2;
      s1_q1     <= pq1[30:22];
      s1_q2     <= pq2[30:22];
      s1_qn     <= pqn[30:22];
      s1_y365_1 <= 24'(s0_p1.ay) * 24'd365;
      s1_y365_2 <= 24'(s0_p2.ay) * 24'd365;
      s1_n1     <= s0_n1;
      s1_m1     <= s0_m1;
      s1_d1     <= s0_d1;
      s1_equal  <= s0_equal;
      s1_off    <= s0_off;
    end
  end

  // stage 2: |365y + y/4 - y/100 + y/400|, leap year and date check
  logic [23:0] mag1, mag2;
  logic [14:0] p100;
  logic        div100, div400, leap;
  logic        valid1;

  always_comb begin
    mag1   = s1_y365_1 + 24'(s1_p1.ay >> 2) - 24'(s1_q1) + 24'(s1_q1 >> 2);
    mag2   = s1_y365_2 + 24'(s1_p2.ay >> 2) - 24'(s1_q2) + 24'(s1_q2 >> 2);
    p100   = 15'(s1_qn) * 15'd100;
    div100 = (s1_n1 == p100);
    div400 = div100 && (s1_qn[1:0] == 2'd0);
    leap   = div400 || ((s1_n1[1:0] == 2'd0) && !div100);
    valid1 = (s1_m1 >= MON_JAN) && (s1_m1 <= MON_DEC) && (s1_d1 != 5'd0) &&
             (s1_d1 <= month_len(s1_m1, leap));
  end

  logic [23:0]        s2_mag1, s2_mag2;
  logic               s2_neg1, s2_neg2;
  logic signed [16:0] s2_base1, s2_base2;
  logic               s2_valid, s2_equal;
  logic signed [22:0] s2_off;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_mag1  <= mag1;
      s2_mag2  <= mag2;
      s2_neg1  <= s1_p1.neg;
      s2_neg2  <= s1_p2.neg;
      s2_base1 <= s1_p1.base;
      s2_base2 <= s1_p2.base;
      s2_valid <= valid1;
      s2_equal <= s1_equal;
      s2_off   <= s1_off;
    end
  end

  // stage 3: signed day numbers
  logic signed [24:0] ext1, ext2, mg1, mg2, jd1, jd2;

  always_comb begin
    ext1 = 25'(s2_base1);
    ext2 = 25'(s2_base2);
    mg1  = $signed({1'b0, s2_mag1});
    mg2  = $signed({1'b0, s2_mag2});
    jd1  = s2_neg1 ? ext1 - mg1 : ext1 + mg1;
    jd2  = s2_neg2 ? ext2 - mg2 : ext2 + mg2;
  end

  logic signed [24:0] s3_jd1, s3_jd2;
  logic               s3_valid, s3_equal;
  logic signed [22:0] s3_off;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_jd1   <= jd1;
      s3_jd2   <= jd2;
      s3_valid <= s2_valid;
      s3_equal <= s2_equal;
      s3_off   <= s2_off;
    end
  end

  // stage 4: difference with saturation, shifted day number and range check
  logic signed [25:0] diff26, js, ja;
  tail_t              tail4;

  always_comb begin
    diff26 = 26'(s3_jd1) - 26'(s3_jd2);
    js     = 26'(s3_jd1) + 26'(s3_off);
    ja     = js + 26'sd32044;
    if (diff26 > DIFF_MAX) begin
      tail4.diff = DIFF_MAX[23:0];
    end else if (diff26 < DIFF_MIN) begin
      tail4.diff = DIFF_MIN[23:0];
    end else begin
      tail4.diff = diff26[23:0];
    end
    tail4.oor   = (js < JD_LO) || (js > JD_HI);
    tail4.valid = s3_valid;
    tail4.equal = s3_equal;
  end

  logic [22:0] s4_a;
  tail_t       s4_tail;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_a    <= ja[22:0];
      s4_tail <= tail4;
    end
  end

  // stage 5: b = (4a+3) / 146097
  logic [50:0] pb;

  always_comb begin
    pb = 51'({s4_a, 2'b11}) * 51'(KB);
  end

  logic [7:0]  s5_b;
  logic [22:0] s5_a;
  tail_t       s5_tail;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_b    <= pb[50:43];
      s5_a    <= s4_a;
      s5_tail <= s4_tail;
    end
  end

  // stage 6: c = a - 146097*b/4
  logic [24:0] tb;
  logic [22:0] cdiff;

  always_comb begin
    tb    = 25'(s5_b) * 25'd146097;
    cdiff = s5_a - tb[24:2];
  end

  logic [15:0] s6_c;
  logic [7:0]  s6_b;
  tail_t       s6_tail;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_c    <= cdiff[15:0];
      s6_b    <= s5_b;
      s6_tail <= s5_tail;
    end
  end

  // stage 7: d = (4c+3) / 1461
  logic [36:0] pd;

  always_comb begin
    pd = 37'({s6_c, 2'b11}) * 37'(KD);
  end

  logic [6:0]  s7_d;
  logic [15:0] s7_c;
  logic [7:0]  s7_b;
  tail_t       s7_tail;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_d    <= pd[35:29];
      s7_c    <= s6_c;
      s7_b    <= s6_b;
      s7_tail <= s6_tail;
    end
  end

  // stage 8: e = c - 1461*d/4
  logic [17:0] td;
  logic [15:0] ediff;

  always_comb begin
    td    = 18'(s7_d) * 18'd1461;
    ediff = s7_c - td[17:2];
  end

  logic [8:0] s8_e;
  logic [6:0] s8_d;
  logic [7:0] s8_b;
  tail_t      s8_tail;

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_e    <= ediff[8:0];
      s8_d    <= s7_d;
      s8_b    <= s7_b;
      s8_tail <= s7_tail;
    end
  end

  // stage 9: m = (5e+2) / 153
  logic [10:0] xm;
  logic [22:0] pm;

  always_comb begin
    xm = 11'(s8_e) * 11'd5 + 11'd2;
    pm = 23'(xm) * 23'(KM);
  end

  logic [3:0] s9_m;
  logic [8:0] s9_e;
  logic [6:0] s9_d;
  logic [7:0] s9_b;
  tail_t      s9_tail;

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s9_m    <= pm[22:19];
      s9_e    <= s8_e;
      s9_d    <= s8_d;
      s9_b    <= s8_b;
      s9_tail <= s8_tail;
    end
  end

  // stage 10: assemble year, month, day; zero when out of range
  logic        hi;
  logic [15:0] yr16;
  logic [3:0]  mo4;
  logic [8:0]  dy9;

  always_comb begin
    hi   = (s9_m >= 4'd10);
    yr16 = 16'(s9_b) * 16'd100 + 16'(s9_d) + 16'(hi) - 16'd4800;
    mo4  = hi ? s9_m - 4'd9 : s9_m + 4'd3;
    dy9  = s9_e - mday_ofs(s9_m) + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (adv[10]) begin
      shifted_year       <= s9_tail.oor ? 15'sd0 : $signed(yr16[14:0]);
      shifted_month      <= s9_tail.oor ? 4'd0 : mo4;
      shifted_day        <= s9_tail.oor ? 5'd0 : dy9[4:0];
      shift_out_of_range <= s9_tail.oor;
      day_difference     <= s9_tail.diff;
      date_valid         <= s9_tail.valid;
      dates_equal        <= s9_tail.equal;
    end
  end

  `ASSERT_ALWAYS(a_oor_zero, clk, rst, out_valid && shift_out_of_range |-> shifted_year == 15'sd0 && shifted_month == 4'd0 && shifted_day == 5'd0, "out of range item has nonzero date")
  `ASSERT_ALWAYS(a_shift_legal, clk, rst, out_valid && !shift_out_of_range |-> shifted_month >= MON_JAN && shifted_month <= MON_DEC && shifted_day != 5'd0, "shifted date not a calendar date")
  `ASSERT_ALWAYS(a_equal_diff, clk, rst, out_valid && dates_equal |-> day_difference == 24'sd0, "equal dates with nonzero difference")
  `ASSERT_ALWAYS(a_stall_cause, clk, rst, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")
  `ASSERT_NEXT(a_bubble, clk, rst, out_valid && !out_stall && !vld[NSTG-2], !out_valid, "item repeated at output")

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for gregorian_date_arithmetic_core: shifted date, day difference,
// validity and equality flags are predicted per item and checked field by field.
// Depends on gda_pkg (pipeline depth) and the core RTL only.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic signed [14:0] yr;
    logic        [3:0]  mo;
    logic        [4:0]  dy;
    logic signed [22:0] ofs;
    logic signed [14:0] oyr;
    logic        [3:0]  omo;
    logic        [4:0]  ody;
  } date_pair_t;

  typedef struct {
    logic signed [14:0] syr;
    logic        [3:0]  smo;
    logic        [4:0]  sdy;
    logic               oor;
    logic signed [23:0] diff;
    logic               valid;
    logic               equal;
  } date_result_t;

  localparam longint DIFF_TOP = 64'sd8388607;
  localparam longint DIFF_BOT = -64'sd8388608;
  localparam int     HOLD_LEN = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [14:0] year = '0;
  logic        [3:0]  month = '0;
  logic        [4:0]  day = '0;
  logic signed [22:0] offset_days = '0;
  logic signed [14:0] other_year = '0;
  logic        [3:0]  other_month = '0;
  logic        [4:0]  other_day = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] shifted_year;
  logic        [3:0]  shifted_month;
  logic        [4:0]  shifted_day;
  logic               shift_out_of_range;
  logic signed [23:0] day_difference;
  logic               date_valid;
  logic               dates_equal;

  date_result_t pending_results[$];
  date_result_t oldest;

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int oor_items = 0;
  int invalid_items = 0;
  int equal_items = 0;
  int clamped_items = 0;
  int input_stall_cycles = 0;
  int hold_requests = 0;

  gregorian_date_arithmetic_core u_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .year               (year),
    .month              (month),
    .day                (day),
    .offset_days        (offset_days),
    .other_year         (other_year),
    .other_month        (other_month),
    .other_day          (other_day),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .shifted_year       (shifted_year),
    .shifted_month      (shifted_month),
    .shifted_day        (shifted_day),
    .shift_out_of_range (shift_out_of_range),
    .day_difference     (day_difference),
    .date_valid         (date_valid),
    .dates_equal        (dates_equal)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Calendar arithmetic, truncating division throughout
  // ---------------------------------------------------------------------------
  function automatic longint day_count(longint y0, longint mo, longint d0);
    longint a, y, m;
    a = (14 - mo) / 12;
    y = y0 + 4800 - a;
    m = mo + 12 * a - 3;
    return d0 + (153 * m + 2) / 5 + 365 * y + y / 4 - y / 100 + y / 400 - 32045;
  endfunction

  function automatic bit is_leap(longint y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic longint month_span(longint y, longint m);
    if (m == 2) return is_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic date_result_t shift_and_compare(date_pair_t p);
    longint jd1, jd2, js, lo, hi, diff, a, b, c, d, e, m;
    date_result_t r;
    jd1 = day_count(p.yr, p.mo, p.dy);
    jd2 = day_count(p.oyr, p.omo, p.ody);
    lo  = day_count(-4700, 1, 1);
    hi  = day_count(9999, 12, 31);
    js  = jd1 + p.ofs;
    r.syr = '0;
    r.smo = '0;
    r.sdy = '0;
    r.oor = 1'b1;
    if (js >= lo && js <= hi) begin
      a = js + 32044;
      b = (4 * a + 3) / 146097;
      c = a - (146097 * b) / 4;
      d = (4 * c + 3) / 1461;
      e = c - (1461 * d) / 4;
      m = (5 * e + 2) / 153;
      r.syr = 15'(100 * b + d - 4800 + m / 10);
      r.smo = 4'(m + 3 - 12 * (m / 10));
      r.sdy = 5'(e - (153 * m + 2) / 5 + 1);
      r.oor = 1'b0;
    end
    diff = jd1 - jd2;
    if (diff > DIFF_TOP) diff = DIFF_TOP;
    if (diff < DIFF_BOT) diff = DIFF_BOT;
    r.diff  = 24'(diff);
    r.valid = (p.mo >= 1 && p.mo <= 12) && (p.dy >= 1) &&
              (p.dy <= month_span(p.yr, p.mo));
    r.equal = (p.yr == p.oyr) && (p.mo == p.omo) && (p.dy == p.ody);
    return r;
  endfunction

  function automatic date_pair_t mk(int y, int mo, int dy, int ofs, int oy, int omo, int ody);
    date_pair_t p;
    p.yr  = 15'(y);
    p.mo  = 4'(mo);
    p.dy  = 5'(dy);
    p.ofs = 23'(ofs);
    p.oyr = 15'(oy);
    p.omo = 4'(omo);
    p.ody = 5'(ody);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one item per call, returns at the edge where it was taken
  // ---------------------------------------------------------------------------
  task automatic send_pair(input date_pair_t p);
    date_result_t r;
    in_valid    <= 1'b1;
    year        <= p.yr;
    month       <= p.mo;
    day         <= p.dy;
    offset_days <= p.ofs;
    other_year  <= p.oyr;
    other_month <= p.omo;
    other_day   <= p.ody;
    do @(posedge clk); while (in_stall);
    r = shift_and_compare(p);
    pending_results.push_back(r);
    items_sent++;
    if (r.oor) oor_items++;
    if (!r.valid) invalid_items++;
    if (r.equal) equal_items++;
    if (r.diff == 24'sh7FFFFF || r.diff == 24'sh800000) clamped_items++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern steps through four modes; long holds on request
  // ---------------------------------------------------------------------------
  int rx_cycle = 0;
  int holds_done = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case ((rx_cycle / 150) % 4)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= rx_cycle[0];
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string nm, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", nm, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall) input_stall_cycles++;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result item with no item outstanding");
          errors++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("shifted_year", oldest.syr, shifted_year);
          check_field("shifted_month", oldest.smo, shifted_month);
          check_field("shifted_day", oldest.sdy, shifted_day);
          check_field("shift_out_of_range", oldest.oor, shift_out_of_range);
          check_field("day_difference", oldest.diff, day_difference);
          check_field("date_valid", oldest.valid, date_valid);
          check_field("dates_equal", oldest.equal, dates_equal);
          results_checked++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_edges();
    send_pair(mk(2024, 2, 29, 1, 2024, 3, 1));
    send_pair(mk(2023, 2, 29, 0, 2023, 2, 28));         // Feb 29 in common year
    send_pair(mk(2000, 2, 29, -366, 2000, 2, 29));      // century leap year
    send_pair(mk(1900, 2, 29, 0, 1900, 3, 1));          // century non-leap
    send_pair(mk(0, 2, 29, 0, -1, 12, 31));
    send_pair(mk(-1, 2, 29, 0, -4, 2, 29));
    send_pair(mk(-400, 2, 29, 0, -100, 2, 29));
    send_pair(mk(-4700, 1, 1, 0, -4700, 1, 1));         // first supported day
    send_pair(mk(-4700, 1, 1, -1, 9999, 12, 31));       // one day below range
    send_pair(mk(9999, 12, 31, 0, 9999, 12, 31));       // last supported day
    send_pair(mk(9999, 12, 31, 1, -4700, 1, 1));        // one day above range
    send_pair(mk(2024, 6, 15, 4194303, 2024, 6, 15));
    send_pair(mk(2024, 6, 15, -4194304, 2024, 6, 16));
    send_pair(mk(-2000, 1, 1, 4194303, 1, 1, 1));
    send_pair(mk(9000, 6, 1, -4194304, 9000, 6, 1));
    send_pair(mk(2021, 0, 0, 0, 2021, 0, 0));           // month and day zero
    send_pair(mk(2021, 15, 31, 0, 2021, 13, 31));       // months past December
    send_pair(mk(2021, 4, 31, 0, 2021, 4, 30));
    send_pair(mk(16383, 15, 31, 0, -16384, 0, 0));      // difference clamps high
    send_pair(mk(-16384, 0, 0, 0, 16383, 15, 31));      // difference clamps low
    send_pair(mk(-16384, 1, 1, 4194303, 0, 0, 0));
    send_pair(mk(0, 0, 0, 0, 0, 0, 0));
    send_pair(mk(-1, 15, 31, -1, -1, 15, 31));
    send_pair(mk(1582, 10, 4, 1, 1582, 10, 15));
  endtask

  task automatic test_random_dates(input int n);
    date_pair_t p;
    int burst;
    int sel;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        pause($urandom_range(0, 4));
        burst = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
      end
      burst--;

      sel = $urandom_range(0, 19);
      if (sel == 0)      p.yr = 15'($urandom);
      else if (sel == 1) p.yr = 15'(-4700 + int'($urandom_range(0, 2)));
      else if (sel == 2) p.yr = 15'(9999 - int'($urandom_range(0, 2)));
      else               p.yr = 15'(int'($urandom_range(0, 14699)) - 4700);
      p.mo = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
      p.dy = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 31));
      if ($urandom_range(0, 9) == 0) begin
        p.mo = 4'd2;
        p.dy = 5'($urandom_range(28, 29));
      end

      case ($urandom_range(0, 3))
        0:       p.ofs = 23'(int'($urandom_range(0, 800)) - 400);
        1:       p.ofs = 23'(int'($urandom_range(0, 200000)) - 100000);
        2:       p.ofs = 23'($urandom);
        default: p.ofs = '0;
      endcase

      case ($urandom_range(0, 7))
        0, 1: begin
          p.oyr = p.yr;
          p.omo = p.mo;
          p.ody = p.dy;
        end
        2, 3: begin
          p.oyr = p.yr;
          p.omo = 4'($urandom_range(0, 15));
          p.ody = 5'($urandom_range(0, 31));
        end
        4: begin
          p.oyr = 15'($urandom);
          p.omo = 4'($urandom);
          p.ody = 5'($urandom);
        end
        default: begin
          p.oyr = 15'(int'($urandom_range(0, 14699)) - 4700);
          p.omo = 4'($urandom_range(1, 12));
          p.ody = 5'($urandom_range(1, 31));
        end
      endcase
      send_pair(p);
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_output_hold();
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 60; i++)
      send_pair(mk(int'($urandom_range(0, 14699)) - 4700, $urandom_range(1, 12),
                   $urandom_range(1, 28), int'($urandom_range(0, 2000)) - 1000,
                   int'($urandom_range(0, 14699)) - 4700, $urandom_range(1, 12),
                   $urandom_range(1, 28)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_random_dates(700);
    test_output_hold();
    test_random_dates(700);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (gda_pkg::NSTG + 8) @(posedge clk);

    $display("Checked %0d results from %0d items: %0d shifted out of range, %0d invalid dates,",
             results_checked, items_sent, oor_items, invalid_items);
    $display("%0d equal pairs, %0d clamped differences, %0d input stall cycles seen",
             equal_items, clamped_items, input_stall_cycles);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
